### design/bda_pkg.sv
// ---------------------------------------------------------------------------
// bda_pkg: shared types and constants for the binary to decimal ASCII block
// Operation codes for the conversion datapath, sequencer states, status
// struct and the fixed field widths of the request and result ports.
// ---------------------------------------------------------------------------
package bda_pkg;

  // fixed port widths
  localparam int VALUE_W      = 32;
  localparam int DIGIT_CHAR_W = 6;
  localparam int NIBBLE_W     = 4;

  // ASCII code of '0'
  localparam logic [DIGIT_CHAR_W-1:0] ASCII_ZERO = DIGIT_CHAR_W'(48);

  // parameter defaults
  localparam int DEF_MAX_DIGITS = 10;
  localparam int DEF_VALUE_BITS = 32;

  // datapath operations
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DABBLE,
    OP_SHIFT
  } bda_op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_EMIT
  } bda_state_e;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic top_zero;   // digit at the output tap is zero
    logic high_zero;  // digits above the kept window are all zero
  } bda_status_t;

endpackage

### design/bda_dabble.sv
// ---------------------------------------------------------------------------
// bda_dabble: shift and add-3 conversion unit
// Holds the binary shift register and the BCD digit register. One dabble
// step per cycle during conversion, then whole-digit left shifts to walk the
// digits past the output tap, most significant first.
// ---------------------------------------------------------------------------
module bda_dabble
  import bda_pkg::*;
#(
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  parameter int BCD_DIGITS  = 11,
  parameter int EMIT_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                  clk_i,
  input  bda_op_e               op_i,
  input  logic [VALUE_W-1:0]    value_i,
  output logic [NIBBLE_W-1:0]   top_digit_o,
  output bda_status_t           status_o
);

  localparam int BCD_W   = BCD_DIGITS * NIBBLE_W;
  localparam int IN_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int TOP_MSB = EMIT_DIGITS * NIBBLE_W - 1;
  localparam int LOW_W   = EMIT_DIGITS * NIBBLE_W;

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [BCD_W-1:0]      adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[i*NIBBLE_W +: NIBBLE_W] >= NIBBLE_W'(5)) begin
        adj[i*NIBBLE_W +: NIBBLE_W] = bcd_q[i*NIBBLE_W +: NIBBLE_W] + NIBBLE_W'(3);
      end else begin
        adj[i*NIBBLE_W +: NIBBLE_W] = bcd_q[i*NIBBLE_W +: NIBBLE_W];
      end
    end
  end

  // next value per operation
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    case (op_i)
      OP_LOAD: begin
        bin_d = VALUE_BITS'(value_i[IN_BITS-1:0]);
        bcd_d = '0;
      end
      OP_DABBLE: begin
        bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
        bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      end
      OP_SHIFT: begin
        bcd_d = {bcd_q[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
      end
      OP_HOLD: begin
        bin_d = bin_q;
      end
      default: begin
        bin_d = bin_q;
      end
    endcase
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // output tap: most significant digit that is kept
  assign top_digit_o       = bcd_q[TOP_MSB -: NIBBLE_W];
  assign status_o.top_zero = (bcd_q[TOP_MSB -: NIBBLE_W] == '0);

  // dropped high digits: when any is set, the kept window keeps its zeros
  if (LOW_W < BCD_W) begin : g_high
    assign status_o.high_zero = (bcd_q[BCD_W-1:LOW_W] == '0);
  end else begin : g_no_high
    assign status_o.high_zero = 1'b1;
  end

endmodule

### design/bda_ctrl.sv
// ---------------------------------------------------------------------------
// bda_ctrl: sequencer for the conversion unit
// Loads a request, runs one dabble step per value bit, skips leading zero
// digits, then strobes out the remaining digits one per cycle.
// ---------------------------------------------------------------------------
module bda_ctrl
  import bda_pkg::*;
#(
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  parameter int EMIT_DIGITS = DEF_MAX_DIGITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  bda_status_t status_i,
  output bda_op_e     op_o,
  output logic        busy_o,
  output logic        strobe_o,
  output logic        last_o
);

  localparam int BIT_CNT_W = $clog2(VALUE_BITS);
  localparam int REM_W     = $clog2(EMIT_DIGITS + 1);

  bda_state_e           state_q, state_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic                 skip;

  // leading zero to drop: only when nothing was cut off above the window
  assign skip = status_i.top_zero && status_i.high_zero && (rem_q > REM_W'(1));

  // next state and counters
  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    rem_d     = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d   = ST_CONVERT;
          bit_cnt_d = '0;
        end
      end
      ST_CONVERT: begin
        bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
        if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
          state_d = ST_SCAN;
          rem_d   = REM_W'(EMIT_DIGITS);
        end
      end
      ST_SCAN: begin
        if (skip) begin
          rem_d = rem_q - REM_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        rem_d = rem_q - REM_W'(1);
        if (rem_q == REM_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath operation
  always_comb begin
    op_o     = OP_HOLD;
    busy_o   = (state_q != ST_IDLE);
    strobe_o = 1'b0;
    last_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) op_o = OP_LOAD;
      end
      ST_CONVERT: begin
        op_o = OP_DABBLE;
      end
      ST_SCAN: begin
        if (skip) op_o = OP_SHIFT;
      end
      ST_EMIT: begin
        op_o     = OP_SHIFT;
        strobe_o = 1'b1;
        last_o   = (rem_q == REM_W'(1));
      end
      default: begin
        op_o = OP_HOLD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      rem_q     <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      rem_q     <= rem_d;
    end
  end

  // a load happens only on an accepted request
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == OP_LOAD) |-> (start_i && state_q == ST_IDLE))
    else $error("load without accepted request");

  // the last digit ends the run
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> (state_q == ST_IDLE))
    else $error("run continues after last digit");

  // digit count stays live while scanning or emitting
  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_EMIT) |-> (rem_q != '0))
    else $error("digit count underflow");

  // an accepted request starts a conversion pass
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_CONVERT))
    else $error("request accepted but no conversion");

endmodule

### design/binary_to_decimal_ascii.sv
// While busy, the block runs VALUE_BITS dabble steps, a leading-zero scan,
// then one strobed digit per cycle, EMIT_DIGITS being MAX_DIGITS capped at
// the BCD width; the last digit comes in the final busy cycle.
// A new request is taken only when the current one is done and busy is low,
// as the serial shift and add-3 unit holds one value. No receiver stall;
// reset returns to idle.
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII digit stream
// Converts one value with a serial double-dabble pass and strobes out its
// decimal digits, most significant first, leading zeros suppressed.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [VALUE_W-1:0]      value_i,
  output logic                    strobe_o,
  output logic [DIGIT_CHAR_W-1:0] digit_char_o,
  output logic                    last_o
);

  // enough BCD digits for any VALUE_BITS-bit number
  localparam int BCD_DIGITS  = (VALUE_BITS * 3) / 10 + 2;
  localparam int EMIT_DIGITS = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;

  bda_op_e               op;
  bda_status_t           status;
  logic [NIBBLE_W-1:0]   top_digit;

  // sequencer
  bda_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .EMIT_DIGITS(EMIT_DIGITS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .op_o    (op),
    .busy_o  (busy),
    .strobe_o(strobe_o),
    .last_o  (last_o)
  );

  // serial conversion unit
  bda_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .BCD_DIGITS (BCD_DIGITS),
    .EMIT_DIGITS(EMIT_DIGITS)
  ) u_dabble (
    .clk_i      (clk_i),
    .op_i       (op),
    .value_i    (value_i),
    .top_digit_o(top_digit),
    .status_o   (status)
  );

  // ASCII encode the digit at the tap
  assign digit_char_o = ASCII_ZERO + DIGIT_CHAR_W'(top_digit);

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the binary to decimal ASCII converter
// Sends directed and random 32-bit values in bursts with random gaps,
// predicts the decimal digit stream of each accepted request and checks
// every strobed digit and its last flag in order.
// ---------------------------------------------------------------------------
module tb_top;
  import bda_pkg::*;

  localparam int NUM_DIGITS = DEF_MAX_DIGITS;
  localparam int NUM_BITS   = DEF_VALUE_BITS;
  localparam int RADIX      = 10;
  localparam int DIGIT_CAP  = 20;
  localparam int DIGIT_LIMIT =
      (NUM_DIGITS < 1) ? 1 : ((NUM_DIGITS > DIGIT_CAP) ? DIGIT_CAP : NUM_DIGITS);
  localparam logic [63:0] VALUE_MASK =
      (NUM_BITS >= 64) ? '1 : ((64'd1 << NUM_BITS) - 64'd1);
  localparam int NUM_RANDOM    = 250;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 60;

  typedef struct packed {
    logic [DIGIT_CHAR_W-1:0] digit_char;
    logic                    last;
  } digit_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [VALUE_W-1:0]      value_i = '0;
  logic                    strobe_o;
  logic [DIGIT_CHAR_W-1:0] digit_char_o;
  logic                    last_o;

  logic [VALUE_W-1:0] value_q[$];   // values waiting to be requested
  digit_t             digit_q[$];   // digits still due from the block
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  int                 gap_left = 0;
  int                 burst_left = 1;

  binary_to_decimal_ascii #(
    .MAX_DIGITS(NUM_DIGITS),
    .VALUE_BITS(NUM_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Decimal digits of one value, most significant first, leading zeros dropped
  function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] value);
    logic [63:0] rest;
    logic [3:0]  dec_digits [DIGIT_CAP];
    int          n;
    digit_t      d;
    rest = 64'(value) & VALUE_MASK;
    n = 0;
    do begin
      dec_digits[n] = 4'(rest % RADIX);
      rest = rest / RADIX;
      n++;
    end while (rest != 0 && n < DIGIT_LIMIT);
    for (int k = n - 1; k >= 0; k--) begin
      d.digit_char = ASCII_ZERO + DIGIT_CHAR_W'(dec_digits[k]);
      d.last = (k == 0);
      digit_q.push_back(d);
    end
  endfunction

  // Request driver: bursts of requests separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      value_i <= '0;
    end else begin
      if (start && !busy) begin
        queue_decimal_digits(value_i);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
          value_i <= $urandom;
        end else if (value_q.size() > 0) begin
          start <= 1'b1;
          value_i <= value_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
          value_i <= $urandom;
        end
      end
    end
  end

  // Digit checker: every strobe must match the oldest expected digit
  always @(posedge clk_i) begin : result_check
    digit_t want;
    if (rst_ni && strobe_o) begin
      if (digit_q.size() == 0) begin
        $error("unexpected digit: digit_char %0d last %0b", digit_char_o, last_o);
        mismatch_count++;
      end else begin
        want = digit_q.pop_front();
        if (digit_char_o !== want.digit_char) begin
          $error("digit_char mismatch: expected %0d, got %0d",
                 want.digit_char, digit_char_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with neither a request nor a digit accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("binary_to_decimal_ascii test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    longint unsigned p;
    longint unsigned lo;
    longint unsigned hi;
    int              nd;

    // directed: zero, single digits, powers of ten and their neighbors,
    // all ones, alternating bits and the ten-digit extremes
    value_q.push_back(32'd0);
    value_q.push_back(32'd1);
    value_q.push_back(32'd9);
    value_q.push_back(32'd10);
    value_q.push_back(32'd99);
    value_q.push_back(32'd100);
    value_q.push_back(32'd101);
    value_q.push_back(32'd12345);
    value_q.push_back(32'd999999);
    value_q.push_back(32'd1000000);
    value_q.push_back(32'd999999999);
    value_q.push_back(32'd1000000000);
    value_q.push_back(32'd1000000001);
    value_q.push_back(32'd1234567890);
    value_q.push_back(32'h8000_0000);
    value_q.push_back(32'h7FFF_FFFF);
    value_q.push_back(32'h5555_5555);
    value_q.push_back(32'hAAAA_AAAA);
    value_q.push_back(32'hFFFF_FFFE);
    value_q.push_back(32'hFFFF_FFFF);
    value_q.push_back(32'd0);

    // random: full range, decade boundaries, small values, chosen digit count
    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 3))
        0: value_q.push_back($urandom);
        1: begin
          p = 1;
          repeat ($urandom_range(1, 9)) p = p * RADIX;
          value_q.push_back(VALUE_W'(p - 1 + $urandom_range(0, 2)));
        end
        2: value_q.push_back($urandom_range(0, 999));
        default: begin
          nd = $urandom_range(1, 10);
          p = 1;
          repeat (nd - 1) p = p * RADIX;
          lo = (nd == 1) ? 0 : p;
          hi = p * RADIX - 1;
          if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
          value_q.push_back(VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1))));
        end
      endcase
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (value_q.size() > 0 || start) @(posedge clk_i);
    while (digit_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("binary_to_decimal_ascii test passed");
    end else begin
      $display("binary_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule
